>>> hdl/cema_pkg.sv
package cema_pkg;

	localparam int NUM_STAGES = 4;
	localparam int STAGE_W    = 2;
	localparam int PC_W       = 4;
	localparam int OUT_FRAC   = 16;
	localparam int OUT_W      = 32;
	localparam int CNT_W      = 16;
	localparam int EQ_W       = 24;
	localparam int TICKS_W    = 25;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// command codes carried in the input tuser
	localparam logic [1:0] OPC_START = 2'd0;
	localparam logic [1:0] OPC_TICK  = 2'd1;
	localparam logic [1:0] OPC_STOP  = 2'd2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EQUIL = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 8'd3;

	// datapath operations of a control word
	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_ACC   = 3'd3;
	localparam logic [2:0] OP_CHECK = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;

	localparam logic [PC_W-1:0] PC_SKIP = 4'd14;

	typedef struct packed {
		logic [2:0]         op;
		logic [STAGE_W-1:0] stage;
		logic               jmp_nz;
		logic [PC_W-1:0]    target;
		logic               done;
	} ucode_t;

	typedef struct packed {
		logic   fire;
		ucode_t uc;
	} seq_ctl_t;

	// per stage: diff, multiply, accumulate; then countdown check, and emit only once the countdown is zero
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			4'd0:  w = '{OP_SUB, 2'd0, 1'b0, 4'd0, 1'b0};
			4'd1:  w = '{OP_MUL, 2'd0, 1'b0, 4'd0, 1'b0};
			4'd2:  w = '{OP_ACC, 2'd0, 1'b0, 4'd0, 1'b0};
			4'd3:  w = '{OP_SUB, 2'd1, 1'b0, 4'd0, 1'b0};
			4'd4:  w = '{OP_MUL, 2'd1, 1'b0, 4'd0, 1'b0};
			4'd5:  w = '{OP_ACC, 2'd1, 1'b0, 4'd0, 1'b0};
			4'd6:  w = '{OP_SUB, 2'd2, 1'b0, 4'd0, 1'b0};
			4'd7:  w = '{OP_MUL, 2'd2, 1'b0, 4'd0, 1'b0};
			4'd8:  w = '{OP_ACC, 2'd2, 1'b0, 4'd0, 1'b0};
			4'd9:  w = '{OP_SUB, 2'd3, 1'b0, 4'd0, 1'b0};
			4'd10: w = '{OP_MUL, 2'd3, 1'b0, 4'd0, 1'b0};
			4'd11: w = '{OP_ACC, 2'd3, 1'b0, 4'd0, 1'b0};
			4'd12: w = '{OP_CHECK, 2'd3, 1'b1, PC_SKIP, 1'b0};
			4'd13: w = '{OP_EMIT, 2'd3, 1'b0, 4'd0, 1'b1};
			default: w = '{OP_NOP, 2'd0, 1'b0, 4'd0, 1'b1};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/cascaded_ema_decimator_unit.sv
// Start and stop commands do not make the block busy; it stays ready for the next command.
// A tick runs a 14-step microprogram: three steps per EMA stage on one shared
// multiplier, then a countdown check and, once the countdown is zero, an emit step.
// Emit registers the datapoint; no new command is taken before the microprogram ends.
// arst_n clears control state, config registers go to their defaults, the block is idle.
module cascaded_ema_decimator_unit #(
	parameter int SAMPLE_BITS     = 16,
	parameter int STATE_FRAC_BITS = 24,
	parameter int COEF_FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample
	input  logic [1:0]                          s_axis_tuser,   // opcode
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [47:0]                         m_axis_tdata,   // datapoint, datapoint_index
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cema_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cema_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int COEF_W = COEF_FRAC_BITS + 1;
	localparam logic [COEF_W-1:0] COEF_RST = COEF_W'((64'd49164 << COEF_FRAC_BITS) >> 16);
	localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

	logic [cema_pkg::CNT_W-1:0]   ratio_q;
	logic [COEF_W-1:0]            coef_q;
	logic [cema_pkg::EQ_W-1:0]    equil_q;
	logic [cema_pkg::CNT_W-1:0]   count_q;

	logic                         running_q;
	logic [cema_pkg::TICKS_W-1:0] ticks_q;
	logic [cema_pkg::CNT_W-1:0]   emitted_q;

	logic                         out_valid_q;
	logic [cema_pkg::OUT_W-1:0]   out_dp_q;
	logic [cema_pkg::CNT_W-1:0]   out_idx_q;
	logic                         out_last_q;

	logic                         accept;
	logic                         busy;
	logic                         launch;
	logic                         do_start;
	logic                         hold;
	logic                         emit_fire;
	logic                         check_fire;
	logic                         is_last;
	logic [cema_pkg::CNT_W-1:0]   ratio_eff;
	logic [COEF_W-1:0]            coef_eff;
	logic [cema_pkg::OUT_W-1:0]   datapoint;
	cema_pkg::seq_ctl_t           ctl;

	assign s_axis_tready = !busy;
	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign do_start = accept && (s_axis_tuser == cema_pkg::OPC_START) && !running_q;
	assign launch   = accept && (s_axis_tuser == cema_pkg::OPC_TICK) && running_q;

	assign ratio_eff = (ratio_q == '0) ? cema_pkg::CNT_W'(1) : ratio_q;
	assign coef_eff  = coef_q[COEF_W-1] ? COEF_ONE : coef_q;

	// emit waits only while the previous datapoint is still unclaimed
	assign hold       = (ctl.uc.op == cema_pkg::OP_EMIT) && out_valid_q && !m_axis_tready;
	assign emit_fire  = ctl.fire && (ctl.uc.op == cema_pkg::OP_EMIT);
	assign check_fire = ctl.fire && (ctl.uc.op == cema_pkg::OP_CHECK);
	assign is_last    = ({1'b0, emitted_q} + 17'd1) >= {1'b0, count_q};

	cema_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.launch  (launch),
		.cond_nz (ticks_q != '0),
		.hold    (hold),
		.busy    (busy),
		.ctl     (ctl)
	);

	cema_dp #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.STATE_FRAC_BITS (STATE_FRAC_BITS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.clear     (do_start),
		.load      (launch),
		.sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.coef      (coef_eff),
		.ctl       (ctl),
		.datapoint (datapoint)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= cema_pkg::CNT_W'(1);
			coef_q  <= COEF_RST;
			equil_q <= '0;
			count_q <= cema_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cema_pkg::REG_RATIO: ratio_q <= cfg_data[cema_pkg::CNT_W-1:0];
				cema_pkg::REG_COEF:  coef_q  <= cfg_data[COEF_W-1:0];
				cema_pkg::REG_EQUIL: equil_q <= cfg_data[cema_pkg::EQ_W-1:0];
				cema_pkg::REG_COUNT: count_q <= cfg_data[cema_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			ticks_q     <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_start) begin
				running_q <= 1'b1;
				ticks_q   <= {1'b0, equil_q} + cema_pkg::TICKS_W'(ratio_eff);
				emitted_q <= '0;
			end else if (accept && (s_axis_tuser == cema_pkg::OPC_STOP)) begin
				running_q <= 1'b0;
			end
			if (check_fire && (ticks_q != '0)) begin
				ticks_q <= ticks_q - 1'b1;
			end
			if (emit_fire) begin
				ticks_q   <= cema_pkg::TICKS_W'(ratio_eff - 1'b1);
				emitted_q <= emitted_q + 1'b1;
				if (is_last) begin
					running_q <= 1'b0;
				end
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_dp_q   <= datapoint;
			out_idx_q  <= emitted_q;
			out_last_q <= is_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_idx_q, out_dp_q};
	assign m_axis_tlast  = out_last_q;

	a_emit_running: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> running_q)
		else $error("datapoint emitted while idle");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && is_last) |=> !running_q)
		else $error("still running after last datapoint");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(emit_fire))
		else $error("output valid without an emit step");

endmodule

>>> hdl/cema_seq.sv
module cema_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                launch,
	input  logic                cond_nz,
	input  logic                hold,
	output logic                busy,
	output cema_pkg::seq_ctl_t  ctl
);

	logic [cema_pkg::PC_W-1:0] pc_q;
	logic                      busy_q;
	cema_pkg::ucode_t          uc;

	always_comb begin
		uc       = cema_pkg::ucode_rom(pc_q);
		ctl.uc   = uc;
		ctl.fire = busy_q && !hold;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (launch) begin
			pc_q   <= '0;
			busy_q <= 1'b1;
		end else if (ctl.fire) begin
			if (uc.done) begin
				busy_q <= 1'b0;
			end else if (uc.jmp_nz && cond_nz) begin
				pc_q <= uc.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/cema_dp.sv
module cema_dp #(
	parameter int SAMPLE_BITS     = 16,
	parameter int STATE_FRAC_BITS = 24,
	parameter int COEF_FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              clear,
	input  logic                              load,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic [COEF_FRAC_BITS:0]           coef,
	input  cema_pkg::seq_ctl_t                ctl,
	output logic [cema_pkg::OUT_W-1:0]        datapoint
);

	localparam int ST_W      = SAMPLE_BITS + STATE_FRAC_BITS;
	localparam int DIFF_W    = ST_W + 1;
	localparam int COEF_W    = COEF_FRAC_BITS + 1;
	localparam int PROD_W    = DIFF_W + COEF_W + 1;
	localparam int OUT_SHIFT = STATE_FRAC_BITS - cema_pkg::OUT_FRAC;

	logic signed [ST_W-1:0]   y_q [cema_pkg::NUM_STAGES];
	logic signed [ST_W-1:0]   x_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [ST_W-1:0]   y_sel;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] inc_full;
	logic signed [ST_W-1:0]   acc_d;
	logic signed [ST_W-1:0]   dp_sh;

	always_comb begin
		y_sel    = y_q[ctl.uc.stage];
		diff_d   = {x_q[ST_W-1], x_q} - {y_sel[ST_W-1], y_sel};
		prod_d   = diff_q * $signed({1'b0, coef});
		// arithmetic shift floors; the true sum always fits the state width
		inc_full = prod_q >>> COEF_FRAC_BITS;
		acc_d    = y_sel + inc_full[ST_W-1:0];
		dp_sh    = y_q[cema_pkg::NUM_STAGES-1] >>> OUT_SHIFT;
	end

	assign datapoint = cema_pkg::OUT_W'(dp_sh);

	always_ff @(posedge clk) begin
		if (clear) begin
			for (int i = 0; i < cema_pkg::NUM_STAGES; i++) begin
				y_q[i] <= '0;
			end
		end
		if (load) begin
			x_q <= {sample, {STATE_FRAC_BITS{1'b0}}};
		end
		if (ctl.fire) begin
			case (ctl.uc.op)
				cema_pkg::OP_SUB: begin
					diff_q <= diff_d;
				end
				cema_pkg::OP_MUL: begin
					prod_q <= prod_d;
				end
				cema_pkg::OP_ACC: begin
					y_q[ctl.uc.stage] <= acc_d;
					x_q               <= acc_d;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> tb/sv/tb_cascaded_ema_decimator_unit.sv
module tb_cascaded_ema_decimator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W = 16;
	localparam int STATE_FRAC = 24;
	localparam int COEF_FRAC = 16;
	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 950;
	localparam logic [1:0] OPC_UNUSED = 2'd3;
	localparam logic [cema_pkg::CFG_IDX_W-1:0] REG_PAST_END = 8'd4;
	localparam logic [cema_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

	typedef struct packed {
		logic [31:0] value;
		logic [15:0] ordinal;
		logic        last;
	} datapoint_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = cema_pkg::OPC_STOP;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cema_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cema_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// filter shadow: registers and measurement state
	logic [15:0] reg_ratio = 16'd1;
	logic [16:0] reg_coef = 17'd49164;
	logic [23:0] reg_equil = 24'd0;
	logic [15:0] reg_count = 16'd1;
	logic run_active = 1'b0;
	longint ema_state [4] = '{default: 0};
	logic [cema_pkg::TICKS_W-1:0] ticks_left = '0;
	logic [15:0] points_out = '0;

	datapoint_t pending_points [$];
	int mismatch_cnt = 0;
	logic src_steady = 1'b0;
	logic sink_steady = 1'b0;

	cascaded_ema_decimator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic int draw_wait(input logic steady);
		return steady ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic store_reg(input logic [cema_pkg::CFG_IDX_W-1:0] idx,
		input logic [cema_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			cema_pkg::REG_RATIO: reg_ratio = val[15:0];
			cema_pkg::REG_COEF:  reg_coef = val[16:0];
			cema_pkg::REG_EQUIL: reg_equil = val[23:0];
			cema_pkg::REG_COUNT: reg_count = val[15:0];
			default: ;
		endcase
	endtask

	// advance the four EMA stages by one accepted item, queue any datapoint
	task automatic advance_filter(input logic [1:0] opc, input logic [SAMPLE_W-1:0] smp);
		logic [15:0] ratio_eff;
		longint coef_eff;
		longint stage_in;
		longint delta;
		datapoint_t dp;
		ratio_eff = (reg_ratio == 16'd0) ? 16'd1 : reg_ratio;
		case (opc)
			cema_pkg::OPC_START: begin
				if (!run_active) begin
					for (int i = 0; i < 4; i++) ema_state[i] = 0;
					ticks_left = {1'b0, reg_equil} + {9'd0, ratio_eff};
					points_out = '0;
					run_active = 1'b1;
				end
			end
			cema_pkg::OPC_STOP: run_active = 1'b0;
			cema_pkg::OPC_TICK: begin
				if (run_active) begin
					coef_eff = (reg_coef > 17'd65536) ? 65536 : longint'(reg_coef);
					stage_in = longint'(signed'(smp)) <<< STATE_FRAC;
					for (int i = 0; i < 4; i++) begin
						delta = (stage_in - ema_state[i]) * coef_eff;
						ema_state[i] = ema_state[i] + (delta >>> COEF_FRAC);
						stage_in = ema_state[i];
					end
					if (ticks_left != '0) begin
						ticks_left = ticks_left - 1'b1;
					end else begin
						ticks_left = {9'd0, ratio_eff} - 1'b1;
						stage_in = ema_state[3] >>> (STATE_FRAC - cema_pkg::OUT_FRAC);
						dp.value = stage_in[31:0];
						dp.ordinal = points_out;
						dp.last = ({16'd0, points_out} + 32'd1) >= {16'd0, reg_count};
						pending_points.push_back(dp);
						points_out = points_out + 16'd1;
						if (dp.last) run_active = 1'b0;
					end
				end
			end
			default: ;
		endcase
	endtask

	// valid stays high after a handshake; it drops only when a gap follows or a drain begins
	task automatic send_cmd(input logic [1:0] opc, input logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = draw_wait(src_steady);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= opc;
		s_axis_tdata <= smp;
		do @(posedge clk); while (!s_axis_tready);
		advance_filter(opc, smp);
	endtask

	task automatic set_reg(input logic [cema_pkg::CFG_IDX_W-1:0] idx,
		input logic [cema_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		int waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_points.size() != 0) begin
			report_mismatch($sformatf("%0d datapoints never arrived", pending_points.size()));
			pending_points.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : datapoint_sink
		int hold;
		datapoint_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = draw_wait(sink_steady);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected datapoint %h", m_axis_tdata));
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[31:0] !== want.value)
					report_mismatch($sformatf("index %0d: datapoint %h, expected %h",
						want.ordinal, m_axis_tdata[31:0], want.value));
				if (m_axis_tdata[47:32] !== want.ordinal)
					report_mismatch($sformatf("datapoint_index %0d, expected %0d",
						m_axis_tdata[47:32], want.ordinal));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("index %0d: last %b, expected %b",
						want.ordinal, m_axis_tlast, want.last));
			end
		end
	end

	// reset values, plus commands that an idle block drops
	task automatic test_reset_measurement();
		send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		send_cmd(cema_pkg::OPC_STOP, 16'h0000);
		send_cmd(OPC_UNUSED, 16'hFFFF);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		send_cmd(cema_pkg::OPC_TICK, 16'h8000);
		drain();
	endtask

	// full weight: each stage copies its input, output hits both rails
	task automatic test_full_weight();
		set_reg(cema_pkg::REG_COEF, 32'h0001_0000);
		set_reg(cema_pkg::REG_COUNT, 32'd3);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		send_cmd(cema_pkg::OPC_TICK, 16'h8000);
		send_cmd(cema_pkg::OPC_TICK, 16'h0000);
		drain();
	endtask

	task automatic test_running_commands();
		set_reg(cema_pkg::REG_RATIO, 32'd2);
		set_reg(cema_pkg::REG_COEF, 32'd12345);
		set_reg(cema_pkg::REG_COUNT, 32'd2);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		send_cmd(cema_pkg::OPC_TICK, 16'h4000);
		send_cmd(cema_pkg::OPC_START, 16'h1234);
		send_cmd(OPC_UNUSED, 16'h5555);
		send_cmd(cema_pkg::OPC_STOP, 16'h0000);
		send_cmd(cema_pkg::OPC_STOP, 16'h0000);
		drain();
	endtask

	// ratio and count of zero, upper data bits must be dropped
	task automatic test_zero_settings();
		set_reg(cema_pkg::REG_RATIO, 32'hABCD_0000);
		set_reg(cema_pkg::REG_COUNT, 32'h1234_0000);
		set_reg(cema_pkg::REG_COEF, 32'hFFFE_0000);
		set_reg(cema_pkg::REG_EQUIL, 32'hFF00_0002);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		for (int i = 0; i < 4; i++) send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		drain();
	endtask

	// coefficient above one saturates; writes past the map change nothing
	task automatic test_coef_saturation();
		set_reg(cema_pkg::REG_COEF, 32'h0001_FFFF);
		set_reg(REG_PAST_END, 32'hFFFF_FFFF);
		set_reg(REG_TOP_INDEX, 32'h0000_0000);
		set_reg(cema_pkg::REG_RATIO, 32'hFFFF_0001);
		set_reg(cema_pkg::REG_COUNT, 32'd2);
		set_reg(cema_pkg::REG_EQUIL, 32'd0);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		send_cmd(cema_pkg::OPC_TICK, 16'hFFFF);
		send_cmd(cema_pkg::OPC_TICK, 16'h0064);
		send_cmd(cema_pkg::OPC_TICK, 16'h8000);
		drain();
	endtask

	// new ratio only takes hold at the next countdown reload
	task automatic test_write_while_running();
		set_reg(cema_pkg::REG_RATIO, 32'd3);
		set_reg(cema_pkg::REG_COUNT, 32'd3);
		set_reg(cema_pkg::REG_COEF, 32'd30000);
		set_reg(cema_pkg::REG_EQUIL, 32'd1);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		for (int i = 0; i < 4; i++) send_cmd(cema_pkg::OPC_TICK, 16'h2000);
		drain();
		set_reg(cema_pkg::REG_RATIO, 32'd1);
		set_reg(cema_pkg::REG_COEF, 32'h0001_0000);
		set_reg(cema_pkg::REG_COUNT, 32'd2);
		send_cmd(cema_pkg::OPC_TICK, 16'hC000);
		send_cmd(cema_pkg::OPC_TICK, 16'h3FFF);
		drain();
	endtask

	task automatic test_longest_spans();
		set_reg(cema_pkg::REG_RATIO, 32'h0000_FFFF);
		set_reg(cema_pkg::REG_EQUIL, 32'h00FF_FFFF);
		set_reg(cema_pkg::REG_COUNT, 32'h0000_FFFF);
		set_reg(cema_pkg::REG_COEF, 32'd1);
		send_cmd(cema_pkg::OPC_START, 16'h0000);
		send_cmd(cema_pkg::OPC_TICK, 16'h7FFF);
		send_cmd(cema_pkg::OPC_TICK, 16'h8000);
		send_cmd(cema_pkg::OPC_STOP, 16'h0000);
		drain();
	endtask

	task automatic randomize_settings();
		logic [15:0] ratio;
		logic [16:0] coef;
		logic [23:0] equil;
		logic [15:0] cnt;
		case ($urandom_range(0, 19))
			0: ratio = 16'd0;
			1, 2, 3: ratio = 16'($urandom_range(5, 16));
			default: ratio = 16'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 9))
			0: coef = 17'h10000;
			1: coef = 17'($urandom_range(65537, 131071));
			2, 3, 4: coef = 17'($urandom_range(0, 65536));
			default: coef = 17'($urandom_range(8192, 65536));
		endcase
		equil = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(0, 4))
			: 24'($urandom_range(5, 30));
		case ($urandom_range(0, 19))
			0: cnt = 16'd0;
			1, 2: cnt = 16'($urandom_range(7, 20));
			default: cnt = 16'($urandom_range(1, 6));
		endcase
		set_reg(cema_pkg::REG_RATIO, {16'($urandom), ratio});
		set_reg(cema_pkg::REG_COEF, {15'($urandom), coef});
		set_reg(cema_pkg::REG_EQUIL, {8'($urandom), equil});
		set_reg(cema_pkg::REG_COUNT, {16'($urandom), cnt});
	endtask

	// measurements with random content; a phase may end mid-measurement,
	// so the next settings land while a measurement is open
	task automatic test_random_measurements();
		int counted;
		int phase_items;
		int pick;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			drain();
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			randomize_settings();
			phase_items = 0;
			while (phase_items < 60) begin
				if (!run_active) begin
					pick = $urandom_range(0, 19);
					if (pick == 0) send_cmd(cema_pkg::OPC_TICK, pick_sample());
					else if (pick == 1) send_cmd(cema_pkg::OPC_STOP, pick_sample());
					else if (pick == 2) send_cmd(OPC_UNUSED, pick_sample());
					send_cmd(cema_pkg::OPC_START, pick_sample());
					phase_items++;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 92) begin
						send_cmd(cema_pkg::OPC_TICK, pick_sample());
						phase_items++;
					end else if (pick < 95) begin
						send_cmd(cema_pkg::OPC_STOP, pick_sample());
						phase_items++;
					end else if (pick < 98) begin
						send_cmd(cema_pkg::OPC_START, pick_sample());
					end else begin
						send_cmd(OPC_UNUSED, pick_sample());
					end
				end
			end
			counted += phase_items;
		end
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_measurement();
		test_full_weight();
		test_running_commands();
		test_zero_settings();
		test_coef_saturation();
		test_write_while_running();
		test_longest_spans();
		test_random_measurements();
		drain();
		if (mismatch_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
